// File: sv/ewba_pkg.sv
// shared types and constants for equal-width bin assignment
package ewba_pkg;

    localparam int unsigned SampleW = 32;
    localparam int unsigned BreakW  = 48;
    localparam int unsigned CountW  = 7;
    localparam int unsigned StatusW = 2;

    typedef enum logic [1:0] {
        OP_ACCUM    = 2'd0,
        OP_FINALIZE = 2'd1,
        OP_CLASSIFY = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EQUAL    = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // divider control
    typedef struct packed {
        logic                start;
        logic [SampleW+15:0] dividend;
        logic [CountW-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SampleW+15:0] quotient;
    } t_div_rsp;

endpackage

// File: sv/ewba_div.sv
// restoring bit-serial divider for the break step
module ewba_div
    import ewba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int unsigned DW = SampleW + 16;

    logic [DW-1:0]     r_quo, n_quo;
    logic [CountW:0]   r_rem, n_rem;
    logic [CountW-1:0] r_dvs;
    logic [5:0]        r_cnt;
    logic              r_busy, r_done;
    logic [CountW:0]   w_trial;

    assign w_trial = {r_rem[CountW-1:0], r_quo[DW-1]};

    always_comb begin
        n_rem = w_trial;
        n_quo = {r_quo[DW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_trial - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: sv/ewba_mem.sv
// break table storage, one write and one registered read port
module ewba_mem
    import ewba_pkg::*;
#(
    parameter int unsigned AW    = 7,
    parameter int unsigned DEPTH = 65
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BreakW-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BreakW-1:0] o_rdata
);
    logic [BreakW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/equal_width_bin_assignment.sv
// equal-width bin assignment: top level with control sequencer
// accumulate gives no word out; classify does a binary search over the break table
// finalize runs a 48-step serial divide, then writes one break per cycle
// one item at a time; the break table port and the divider set the rate
// the input waits while a result word is held in the output register
// reset (synchronous, active low) clears min/max, flags, bin count to 8
module equal_width_bin_assignment
    import ewba_pkg::*;
#(
    parameter int unsigned MAX_BINS   = 64,
    parameter int unsigned GROUP_BASE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,  // sample_value
    input  logic [1:0]          s_axis_tuser,  // operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,  // group[6:0], status[8:7], zero pad
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CountW-1:0]   i_cfg_data     // bin_count
);
    localparam int unsigned AW = $clog2(MAX_BINS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_FILL  = 6'b000100,
        S_RDHI  = 6'b001000,
        S_CHK   = 6'b010000,
        S_SRCH  = 6'b100000
    } t_state;

    t_state r_state;
    logic signed [SampleW-1:0] r_min, r_max, r_x;
    logic r_seen, r_ready;
    logic [CountW-1:0] r_cfg;
    logic [AW:0] r_lat, r_cnt, r_lo, r_hi, r_mid;
    logic signed [BreakW-1:0] r_acc, r_step;
    logic r_ov;
    logic [CountW-1:0] r_grp;
    logic [StatusW-1:0] r_st;
    logic r_chk_lo;

    logic w_acc, w_out_free;
    logic [AW:0] w_clamp;
    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [BreakW-1:0] w_wdata, w_rdata;
    logic signed [BreakW-1:0] w_xq;
    logic signed [SampleW-1:0] w_s;
    t_op w_op;

    assign w_s  = $signed(s_axis_tdata);
    assign w_op = t_op'(s_axis_tuser);
    assign w_out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_xq = {r_x, 16'd0};

    always_comb begin
        if (r_cfg == '0) w_clamp = (AW+1)'(1);
        else if ({{(AW+1){1'b0}}, r_cfg} > (AW+CountW+1)'(MAX_BINS))
            w_clamp = (AW+1)'(MAX_BINS);
        else w_clamp = (AW+1)'(r_cfg);
    end

    assign w_dreq.start    = w_acc && (w_op == OP_FINALIZE) && r_seen && (r_min != r_max);
    assign w_dreq.dividend = {32'(r_max - r_min), 16'd0};
    assign w_dreq.divisor  = CountW'(w_clamp);

    ewba_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = r_acc;
        if (r_state == S_FILL) begin
            w_we = 1'b1;
            if (r_cnt == r_lat) w_wdata = {r_max, 16'd0};
        end
        w_raddr = r_mid[AW-1:0];
    end

    ewba_mem #(.AW(AW), .DEPTH(MAX_BINS + 1)) u_mem (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= '0;
            r_max   <= '0;
            r_seen  <= 1'b0;
            r_ready <= 1'b0;
            r_cfg   <= CountW'(8);
            r_lat   <= (AW+1)'(1);
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (m_axis_tready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (w_op)
                            OP_ACCUM: begin
                                r_ready <= 1'b0;
                                r_seen  <= 1'b1;
                                if (!r_seen || r_ready) begin
                                    r_min <= w_s;
                                    r_max <= w_s;
                                end else begin
                                    if (w_s < r_min) r_min <= w_s;
                                    if (w_s > r_max) r_max <= w_s;
                                end
                            end
                            OP_FINALIZE: begin
                                if (!r_seen) begin
                                    r_ready <= 1'b0;
                                    r_ov <= 1'b1; r_grp <= '0; r_st <= ST_EMPTY;
                                end else if (r_min == r_max) begin
                                    r_ready <= 1'b0;
                                    r_ov <= 1'b1; r_grp <= '0; r_st <= ST_EQUAL;
                                end else begin
                                    r_lat   <= w_clamp;
                                    r_state <= S_DIV;
                                end
                            end
                            OP_CLASSIFY: begin
                                if (!r_ready) begin
                                    r_ov <= 1'b1; r_grp <= '0; r_st <= ST_RANGE;
                                end else begin
                                    r_x   <= w_s;
                                    r_lo  <= '0;
                                    r_hi  <= r_lat;
                                    r_mid <= '0;
                                    r_state <= S_RDHI;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_step  <= $signed(w_drsp.quotient);
                        r_acc   <= {r_min, 16'd0};
                        r_cnt   <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_acc <= r_acc + r_step;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_lat) begin
                        r_ready <= 1'b1;
                        r_ov <= 1'b1; r_grp <= '0; r_st <= ST_OK;
                        r_state <= S_IDLE;
                    end
                end
                S_RDHI: begin
                    // break 0 is being read; queue the top break
                    r_mid <= r_hi;
                    r_chk_lo <= 1'b1;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_chk_lo) begin
                        r_chk_lo <= 1'b0;
                        if (w_xq < $signed(w_rdata)) begin
                            r_ov <= 1'b1; r_grp <= '0; r_st <= ST_RANGE;
                            r_state <= S_IDLE;
                        end
                    end else if (w_xq > $signed(w_rdata)) begin
                        r_ov <= 1'b1; r_grp <= '0; r_st <= ST_RANGE;
                        r_state <= S_IDLE;
                    end else if (r_hi - r_lo < 2) begin
                        r_ov <= 1'b1; r_grp <= CountW'(r_lo + GROUP_BASE); r_st <= ST_OK;
                        r_state <= S_IDLE;
                    end else begin
                        r_mid <= (r_lo + r_hi) >> 1;
                        r_state <= S_SRCH;
                        r_chk_lo <= 1'b1;
                    end
                end
                S_SRCH: begin
                    // r_chk_lo toggles: set = read pending, clear = data valid
                    if (r_chk_lo) begin
                        r_chk_lo <= 1'b0;
                    end else begin
                        logic [AW:0] v_lo, v_hi;
                        v_lo = r_lo;
                        v_hi = r_hi;
                        if (w_xq >= $signed(w_rdata)) v_lo = r_mid;
                        else v_hi = r_mid;
                        r_lo <= v_lo;
                        r_hi <= v_hi;
                        if (v_hi - v_lo < 2) begin
                            r_ov <= 1'b1;
                            r_grp <= CountW'(v_lo + GROUP_BASE);
                            r_st <= ST_OK;
                            r_state <= S_IDLE;
                        end else begin
                            r_mid <= (v_lo + v_hi) >> 1;
                            r_chk_lo <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_st, r_grp};
endmodule

// File: sv/ewba_checker.sv
// port-level checks for equal-width bin assignment
module ewba_checker
    import ewba_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_grp0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8:7] != ST_OK |-> m_axis_tdata[6:0] == 7'd0)
        else $error("nonzero group with error status");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
        else $error("pad bits set");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");
endmodule

bind equal_width_bin_assignment ewba_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// File: tb/tb_equal_width_bin_assignment.sv
// self-checking testbench for equal-width bin assignment
`timescale 1ns / 1ps

module tb_equal_width_bin_assignment
    import ewba_pkg::*;
();

    localparam int MaxBins = 64;
    localparam int GroupBase = 0;
    localparam int StallLimit = 20000;
    localparam int DrainWait = 400;
    localparam int LongHold = 300;

    typedef struct packed {
        logic [6:0] group;
        t_status    status;
    } t_result;

    typedef struct {
        t_op         op;
        logic [31:0] sample;
        logic        has_exp;
        t_result     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    equal_width_bin_assignment #(.MAX_BINS(MaxBins), .GROUP_BASE(GroupBase)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // binning state mirror
    logic [6:0]         bin_reg;
    logic signed [31:0] lo_sample, hi_sample;
    logic               seen_any, edges_valid;
    logic signed [63:0] edge_tab [0:MaxBins];
    int unsigned        edge_bins;

    t_result  pending_results[$];
    int       mismatches;
    int       idle_cycles;
    bit       hold_rx;
    bit       stim_done;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic reset_mirror();
        bin_reg = 7'd8;
        lo_sample = '0;
        hi_sample = '0;
        seen_any = 1'b0;
        edges_valid = 1'b0;
        edge_bins = 1;
    endtask

    // advances the mirror, returns 1 when a result word follows
    function automatic bit bin_sample(input t_op op, input logic signed [31:0] v,
                                      output t_result r);
        int unsigned cnt;
        logic [63:0] step;
        logic signed [63:0] x;
        int unsigned lo, hi, mid;
        r = '0;
        case (op)
            OP_ACCUM: begin
                if (edges_valid) begin
                    edges_valid = 1'b0;
                    seen_any = 1'b0;
                end
                if (!seen_any) begin
                    lo_sample = v;
                    hi_sample = v;
                    seen_any = 1'b1;
                end else begin
                    if (v < lo_sample) lo_sample = v;
                    if (v > hi_sample) hi_sample = v;
                end
                return 1'b0;
            end
            OP_FINALIZE: begin
                cnt = bin_reg;
                if (cnt < 1) cnt = 1;
                if (cnt > MaxBins) cnt = MaxBins;
                if (!seen_any) begin
                    edges_valid = 1'b0;
                    r.status = ST_EMPTY;
                    return 1'b1;
                end
                if (lo_sample == hi_sample) begin
                    edges_valid = 1'b0;
                    r.status = ST_EQUAL;
                    return 1'b1;
                end
                step = (64'(64'(hi_sample) - 64'(lo_sample)) << 16) / 64'(cnt);
                edge_tab[0] = 64'(lo_sample) <<< 16;
                for (int i = 1; i < cnt; i++) edge_tab[i] = edge_tab[i-1] + step;
                edge_tab[cnt] = 64'(hi_sample) <<< 16;
                edge_bins = cnt;
                edges_valid = 1'b1;
                r.status = ST_OK;
                return 1'b1;
            end
            OP_CLASSIFY: begin
                if (!edges_valid) begin
                    r.status = ST_RANGE;
                    return 1'b1;
                end
                x = 64'(v) <<< 16;
                lo = 0;
                hi = edge_bins;
                if (x < edge_tab[0] || x > edge_tab[hi]) begin
                    r.status = ST_RANGE;
                    return 1'b1;
                end
                while (hi - lo >= 2) begin
                    mid = (hi + lo) / 2;
                    if (x >= edge_tab[mid]) lo = mid;
                    else hi = mid;
                end
                r.group = 7'(lo + GroupBase);
                r.status = ST_OK;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // valid stays high after the handshake unless an idle gap or a stop follows
    task automatic send_item(input t_op op, input logic [31:0] v,
                             input bit has_exp, input t_result exp);
        t_result r;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        if (bin_sample(op, v, r)) begin
            if (has_exp && r != exp)
                $display("directed row disagrees with predictor: op %s", op.name());
            pending_results.push_back(has_exp ? exp : r);
        end
    endtask

    task automatic write_bins(input logic [6:0] n);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bin_reg = n;
    endtask

    function automatic logic [31:0] rand_sample(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
        endcase
    endfunction

    // well-formed load pass, finalize and classify burst, with some noise
    task automatic random_pass();
        int mode, n_load, n_cls, k;
        logic [31:0] v;
        mode = $urandom_range(0, 2);
        n_load = $urandom_range(0, 6);
        n_cls = $urandom_range(3, 12);
        for (int i = 0; i < n_load; i++) send_item(OP_ACCUM, rand_sample(mode), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) send_item(OP_CLASSIFY, rand_sample(mode), 1'b0, '0);
        send_item(OP_FINALIZE, $urandom(), 1'b0, '0);
        for (int i = 0; i < n_cls; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) send_item(OP_UNUSED, $urandom(), 1'b0, '0);
            else if (k < 4) send_item(OP_CLASSIFY, rand_sample(mode), 1'b0, '0);
            else if (k < 8 && edges_valid) send_item(OP_CLASSIFY, 32'(hi_sample), 1'b0, '0);
            else if (k < 10 && edges_valid) send_item(OP_CLASSIFY, 32'(lo_sample), 1'b0, '0);
            else if (edges_valid) begin
                v = 32'(lo_sample + $signed(32'($urandom_range(0, 32'(hi_sample - lo_sample)))));
                send_item(OP_CLASSIFY, v, 1'b0, '0);
            end else send_item(OP_CLASSIFY, rand_sample(mode), 1'b0, '0);
        end
    endtask

    // result side: compare each accepted word with the predictor
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.group = m_axis_tdata[6:0];
            got.status = t_status'(m_axis_tdata[8:7]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.group !== want.group || got.status !== want.status
                        || m_axis_tdata[15:9] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: group exp %0d got %0d, status exp %0d got %0d",
                                 want.group, got.group, want.status, got.status);
                end
            end
        end
    end

    // ready side: random stalls and one long hold-off
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_rx && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
            end else begin
                gap = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without a handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || stim_done)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("tb_equal_width_bin_assignment NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        int cnt;
        hold_rx = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ACCUM;
        i_cfg_valid = 1'b0;
        i_cfg_data = 7'd8;
        reset_mirror();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: errors after reset, extremes, exact breaks, unused op
        rows = '{
            '{OP_CLASSIFY, 32'h0000_0000, 1'b1, '{7'd0, ST_RANGE}},
            '{OP_FINALIZE, 32'hFFFF_FFFF, 1'b1, '{7'd0, ST_EMPTY}},
            '{OP_UNUSED,   32'h1234_5678, 1'b0, '0},
            '{OP_ACCUM,    32'h0001_0000, 1'b0, '0},
            '{OP_ACCUM,    32'h0001_0000, 1'b0, '0},
            '{OP_FINALIZE, 32'h0000_0000, 1'b1, '{7'd0, ST_EQUAL}},
            '{OP_CLASSIFY, 32'h0001_0000, 1'b1, '{7'd0, ST_RANGE}},
            '{OP_ACCUM,    32'h8000_0000, 1'b0, '0},
            '{OP_ACCUM,    32'h7FFF_FFFF, 1'b0, '0},
            '{OP_ACCUM,    32'h0000_0000, 1'b0, '0},
            '{OP_FINALIZE, 32'h0000_0000, 1'b1, '{7'd0, ST_OK}},
            '{OP_CLASSIFY, 32'h8000_0000, 1'b1, '{7'd0, ST_OK}},
            '{OP_CLASSIFY, 32'h7FFF_FFFF, 1'b1, '{7'd7, ST_OK}},
            '{OP_CLASSIFY, 32'h0000_0000, 1'b0, '0},
            '{OP_CLASSIFY, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_ACCUM,    32'h0000_0000, 1'b0, '0},
            '{OP_ACCUM,    32'h0000_0008, 1'b0, '0},
            '{OP_FINALIZE, 32'h0000_0000, 1'b1, '{7'd0, ST_OK}},
            '{OP_CLASSIFY, 32'h0000_0001, 1'b1, '{7'd1, ST_OK}},
            '{OP_CLASSIFY, 32'h0000_0009, 1'b1, '{7'd0, ST_RANGE}},
            '{OP_CLASSIFY, 32'hFFFF_FFFF, 1'b1, '{7'd0, ST_RANGE}},
            '{OP_CLASSIFY, 32'h0000_0004, 1'b1, '{7'd4, ST_OK}},
            '{OP_CLASSIFY, 32'h0000_0008, 1'b1, '{7'd7, ST_OK}}
        };
        foreach (rows[i]) send_item(rows[i].op, rows[i].sample, rows[i].has_exp, rows[i].exp);

        // latched count: a write does not change classify until next finalize
        write_bins(7'd1);
        send_item(OP_CLASSIFY, 32'h0000_0008, 1'b1, '{7'd7, ST_OK});
        send_item(OP_FINALIZE, 32'h0, 1'b1, '{7'd0, ST_OK});
        send_item(OP_CLASSIFY, 32'h0000_0008, 1'b1, '{7'd0, ST_OK});

        // random passes over several bin counts, extremes included
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: cnt = 0;
                1: cnt = 64;
                2: cnt = 127;
                3: cnt = 65;
                4: cnt = 2;
                default: cnt = $urandom_range(0, 127);
            endcase
            write_bins(7'(cnt));
            if (ph == 3) hold_rx = 1'b1;
            for (int p = 0; p < 8; p++) random_pass();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        stim_done = 1'b1;
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_equal_width_bin_assignment OK");
        else
            $display("tb_equal_width_bin_assignment NOT OK");
        $finish;
    end

endmodule
